[hdl/hba_pkg.sv]
// Package for the heap block allocator: widths, codes, states, defaults.
// No dependencies.
package hba_pkg;
  localparam int MAX_BLOCKS_DEF   = 64;
  localparam int HEADER_BYTES_DEF = 16;
  localparam int SZ_W   = 25;
  localparam int ADDR_W = 32;
  localparam int SPLIT_W = 13;
  localparam logic [SZ_W-1:0] ROUND_MASK = 25'd15;
  localparam logic [SZ_W-1:0] PAGE_MASK  = 25'd4095;
  localparam logic [SZ_W-1:0] BEST_FIT_ABOVE = 25'd4096;

  typedef enum logic [1:0] {
    ACT_ALLOC = 2'd0, ACT_FREE = 2'd1, ACT_INIT = 2'd2, ACT_NONE = 2'd3
  } act_t;

  typedef enum logic [2:0] {
    ERR_NONE = 3'd0, ERR_ZERO = 3'd1, ERR_NOFIT = 3'd2, ERR_BADADDR = 3'd3,
    ERR_NOTALLOC = 3'd4, ERR_NOTINIT = 3'd5
  } err_t;

  typedef enum logic [1:0] {
    CFG_BASE = 2'd0, CFG_BYTES = 2'd1, CFG_SPLIT = 2'd2
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SCAN, ST_SCANW, ST_SPLIT, ST_INS, ST_FREEA, ST_FREEB,
    ST_FREEC, ST_DEL, ST_STATS, ST_STATW, ST_OUT
  } state_t;
endpackage

[hdl/heap_block_allocator.sv]
// Heap block allocator top level: block table memory and its sequencer.
// Depends on hba_pkg.
//
// Usage: write heap_base, heap_bytes and min_split_bytes through the cfg_
// channel (valid/ready, always ready), then send init, alloc and free
// requests on the in_ channel. Each request yields one result on the out_
// channel. A request is taken when in_valid is high and in_stall is low; the
// block holds in_stall high from acceptance until its result is taken.
// The sequencer walks the table one entry at a time, reading each entry in
// one state and using it in the next (SCAN/SCANW for a scan, STATS/STATW
// for the statistics pass). When an allocate splits a block or a free
// merges, entries shift one per cycle through the single-port table.
// Requests answered without touching the table go straight to the output
// register.
// The result waits in the output register while out_stall is high, and the
// next request waits for it.
// Reset empties the table (count 0, heap not ready), min_split_bytes = 16;
// the table memory itself is not cleared.
module heap_block_allocator #(
  parameter int MAX_BLOCKS   = hba_pkg::MAX_BLOCKS_DEF,
  parameter int HEADER_BYTES = hba_pkg::HEADER_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [1:0]                  cfg_index,
  input  logic [31:0]                 cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_action,
  input  logic [hba_pkg::SZ_W-1:0]    in_request_bytes,
  input  logic [hba_pkg::ADDR_W-1:0]  in_release_addr,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_ok,
  output logic [2:0]                  out_error_code,
  output logic [hba_pkg::ADDR_W-1:0]  out_payload_addr,
  output logic [hba_pkg::SZ_W-1:0]    out_granted_bytes,
  output logic [hba_pkg::SZ_W-1:0]    out_free_total,
  output logic [hba_pkg::SZ_W-1:0]    out_max_free
);
  import hba_pkg::*;

  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam logic [CW-1:0] MAXC = CW'(MAX_BLOCKS);
  localparam logic [SZ_W+1:0] HDR = (SZ_W+2)'(HEADER_BYTES);
  localparam int EW = 2 * SZ_W + 1;

  // Configuration registers
  logic [31:0] base_r;
  logic [SZ_W-1:0] bytes_r;
  logic [SPLIT_W-1:0] split_r;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
      bytes_r <= '0;
      split_r <= SPLIT_W'(16);
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_BASE:  base_r  <= cfg_data;
        CFG_BYTES: bytes_r <= cfg_data[SZ_W-1:0];
        CFG_SPLIT: split_r <= cfg_data[SPLIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Block table memory: {offset, payload, free}
  logic [EW-1:0] mem [MAX_BLOCKS];
  logic [EW-1:0] rd_q;
  logic          we;
  logic [IW-1:0] waddr, raddr;
  logic [EW-1:0] wdata;
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_q <= mem[raddr];
  end
  logic [SZ_W-1:0] rd_off, rd_pay;
  logic rd_free;
  assign rd_off  = rd_q[EW-1 -: SZ_W];
  assign rd_pay  = rd_q[SZ_W:1];
  assign rd_free = rd_q[0];

  // Sequencer state
  state_t st_r, st_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic ready_r, ready_nxt;
  logic [31:0] start_r, start_nxt;
  logic [SZ_W-1:0] len_r, len_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [CW-1:0] j_r, j_nxt;
  logic [IW-1:0] pick_r, pick_nxt;
  logic found_r, found_nxt;
  logic [SZ_W:0] size_r, size_nxt;
  logic [SZ_W-1:0] best_r, best_nxt;
  logic [SZ_W-1:0] poff_r, poff_nxt;
  logic [SZ_W-1:0] ppay_r, ppay_nxt;
  logic [SZ_W-1:0] mpay_r, mpay_nxt;
  logic [SZ_W-1:0] rel_r, rel_nxt;
  logic [1:0] act_r, act_nxt;
  logic ok_r, ok_nxt;
  logic [2:0] err_r, err_nxt;
  logic [31:0] addr_r, addr_nxt;
  logic [SZ_W-1:0] gr_r, gr_nxt, tot_r, tot_nxt, lg_r, lg_nxt;
  logic ov_r, ov_nxt;

  logic acc;
  assign acc = in_valid && !in_stall;
  assign in_stall = (st_r != ST_IDLE);

  // Shared datapath terms
  logic [SZ_W+1:0] need;
  logic [SZ_W:0] rnd;
  logic [SZ_W-1:0] alen;
  logic [31:0] relw;
  assign need = {1'b0, size_r} + HDR + (SZ_W+2)'(split_r);
  assign rnd  = ({1'b0, in_request_bytes} + {1'b0, ROUND_MASK}) & ~{1'b0, ROUND_MASK};
  assign alen = bytes_r & ~PAGE_MASK;
  assign relw = in_release_addr - start_r;

  // Next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: if (acc) begin
        st_nxt = ST_OUT;
        if (act_t'(in_action) == ACT_INIT) begin
          st_nxt = ({2'b00, alen} < HDR + (SZ_W+2)'(split_r)) ? ST_OUT : ST_STATS;
        end else if (act_t'(in_action) == ACT_NONE) begin
          st_nxt = ready_r ? ST_STATS : ST_OUT;
        end else if (!ready_r) begin
          st_nxt = ST_OUT;
        end else if (act_t'(in_action) == ACT_ALLOC) begin
          st_nxt = (in_request_bytes == '0) ? ST_STATS : ST_SCAN;
        end else begin
          st_nxt = (in_release_addr == '0 || in_release_addr[3:0] != 4'd0 ||
                    relw >= {7'd0, len_r}) ? ST_STATS : ST_SCAN;
        end
      end
      ST_SCAN:  st_nxt = (i_r >= cnt_r) ? ((act_r == ACT_ALLOC && found_r) ?
                          ST_SPLIT : ST_STATS) : ST_SCANW;
      ST_SCANW: begin
        st_nxt = ST_SCAN;
        if (act_r == ACT_ALLOC) begin
          if (rd_free && {1'b0, rd_pay} >= size_r && size_r <= {1'b0, BEST_FIT_ABOVE})
            st_nxt = ST_SPLIT;
        end else if ({2'b00, rd_off} + HDR == {2'b00, rel_r}) begin
          st_nxt = rd_free ? ST_STATS : ST_FREEA;
        end
      end
      ST_SPLIT: st_nxt = ({1'b0, ppay_r} >= need && cnt_r < MAXC) ? ST_INS : ST_STATS;
      ST_INS:   st_nxt = (j_r == CW'(pick_r) + CW'(1)) ? ST_STATS : ST_INS;
      ST_FREEA: st_nxt = ST_FREEB;
      ST_FREEB: st_nxt = ST_FREEC;
      ST_FREEC: st_nxt = ST_DEL;
      ST_DEL:   st_nxt = (i_r + CW'(1) >= cnt_r) ? ST_STATS : ST_DEL;
      ST_STATS: st_nxt = (i_r >= cnt_r || !ready_r) ? ST_OUT : ST_STATW;
      ST_STATW: st_nxt = ST_STATS;
      ST_OUT:   st_nxt = (!ov_r || !out_stall) && ov_r ? ST_IDLE : ST_OUT;
      default:  st_nxt = ST_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    cnt_nxt = cnt_r; ready_nxt = ready_r; start_nxt = start_r; len_nxt = len_r;
    i_nxt = i_r; j_nxt = j_r; pick_nxt = pick_r; found_nxt = found_r;
    size_nxt = size_r; best_nxt = best_r; poff_nxt = poff_r; ppay_nxt = ppay_r;
    mpay_nxt = mpay_r; rel_nxt = rel_r; act_nxt = act_r;
    ok_nxt = ok_r; err_nxt = err_r; addr_nxt = addr_r; gr_nxt = gr_r;
    tot_nxt = tot_r; lg_nxt = lg_r; ov_nxt = ov_r;
    we = 1'b0; waddr = '0; wdata = '0; raddr = i_r[IW-1:0];
    unique case (st_r)
      ST_IDLE: if (acc) begin
        act_nxt = in_action; ok_nxt = 1'b0; err_nxt = ERR_NONE;
        addr_nxt = '0; gr_nxt = '0; tot_nxt = '0; lg_nxt = '0;
        i_nxt = '0; found_nxt = 1'b0; best_nxt = '1;
        size_nxt = rnd;
        rel_nxt = relw[SZ_W-1:0];
        if (act_t'(in_action) == ACT_INIT) begin
          ready_nxt = 1'b0; cnt_nxt = '0;
          if ({2'b00, alen} < HDR + (SZ_W+2)'(split_r)) begin
            err_nxt = ERR_NOTINIT;
          end else begin
            start_nxt = (base_r + 32'd4095) & ~32'd4095;
            len_nxt = alen;
            we = 1'b1; waddr = '0;
            wdata = {{SZ_W{1'b0}}, alen - SZ_W'(HEADER_BYTES), 1'b1};
            cnt_nxt = CW'(1); ready_nxt = 1'b1; ok_nxt = 1'b1;
          end
        end else if (act_t'(in_action) != ACT_NONE) begin
          if (!ready_r) err_nxt = ERR_NOTINIT;
          else if (act_t'(in_action) == ACT_ALLOC) begin
            if (in_request_bytes == '0) err_nxt = ERR_ZERO;
          end else if (in_release_addr == '0 || in_release_addr[3:0] != 4'd0 ||
                       relw >= {7'd0, len_r}) err_nxt = ERR_BADADDR;
        end
      end
      ST_SCAN: begin
        if (i_r >= cnt_r) begin
          if (act_r == ACT_ALLOC) begin
            if (!found_r) err_nxt = ERR_NOFIT;
          end else err_nxt = ERR_BADADDR;
          i_nxt = '0;
        end
      end
      ST_SCANW: begin
        i_nxt = i_r + CW'(1);
        if (act_r == ACT_ALLOC) begin
          if (rd_free && {1'b0, rd_pay} >= size_r) begin
            if (size_r <= {1'b0, BEST_FIT_ABOVE}) begin
              pick_nxt = i_r[IW-1:0]; found_nxt = 1'b1;
              poff_nxt = rd_off; ppay_nxt = rd_pay;
            end else if (rd_pay < best_r) begin
              best_nxt = rd_pay; pick_nxt = i_r[IW-1:0]; found_nxt = 1'b1;
              poff_nxt = rd_off; ppay_nxt = rd_pay;
            end
          end
        end else if ({2'b00, rd_off} + HDR == {2'b00, rel_r}) begin
          pick_nxt = i_r[IW-1:0]; poff_nxt = rd_off; ppay_nxt = rd_pay;
          if (rd_free) err_nxt = ERR_NOTALLOC;
          i_nxt = '0;
        end
      end
      ST_SPLIT: begin
        ok_nxt = 1'b1; i_nxt = '0;
        addr_nxt = start_r + {7'd0, poff_r} + 32'(HEADER_BYTES);
        we = 1'b1; waddr = pick_r;
        if ({1'b0, ppay_r} >= need && cnt_r < MAXC) begin
          wdata = {poff_r, size_r[SZ_W-1:0], 1'b0};
          gr_nxt = size_r[SZ_W-1:0];
          mpay_nxt = ppay_r - size_r[SZ_W-1:0] - SZ_W'(HEADER_BYTES);
          j_nxt = cnt_r;
          raddr = cnt_r[IW-1:0] - IW'(1);
          cnt_nxt = cnt_r + CW'(1);
        end else begin
          wdata = {poff_r, ppay_r, 1'b0};
          gr_nxt = ppay_r;
        end
      end
      ST_INS: begin
        // rd_q holds entry j-1; shift it up, final cycle writes new block
        raddr = j_r[IW-1:0] - IW'(2);
        we = 1'b1;
        if (j_r == CW'(pick_r) + CW'(1)) begin
          waddr = j_r[IW-1:0];
          wdata = {poff_r + size_r[SZ_W-1:0] + SZ_W'(HEADER_BYTES), mpay_r, 1'b1};
        end else begin
          waddr = j_r[IW-1:0]; wdata = rd_q;
          j_nxt = j_r - CW'(1);
        end
      end
      ST_FREEA: begin
        raddr = pick_r + IW'(1);
        mpay_nxt = ppay_r;
      end
      ST_FREEB: begin
        // rd_q = next entry; read previous next
        raddr = pick_r - IW'(1);
        j_nxt = '0;
        if (CW'(pick_r) + CW'(1) < cnt_r && rd_free) begin
          mpay_nxt = mpay_r + rd_pay + SZ_W'(HEADER_BYTES);
          j_nxt = CW'(1);
        end
      end
      ST_FREEC: begin
        // rd_q = previous entry; write merged block and set shift range
        ok_nxt = 1'b1;
        we = 1'b1;
        if (pick_r != '0 && rd_free) begin
          waddr = pick_r - IW'(1);
          wdata = {rd_off, rd_pay + mpay_r + SZ_W'(HEADER_BYTES), 1'b1};
          i_nxt = CW'(pick_r);
          cnt_nxt = cnt_r - CW'(1) - j_r;
          j_nxt = CW'(pick_r) + CW'(1) + j_r;
        end else begin
          waddr = pick_r;
          wdata = {poff_r, mpay_r, 1'b1};
          i_nxt = CW'(pick_r) + CW'(1);
          cnt_nxt = cnt_r - j_r;
          j_nxt = CW'(pick_r) + CW'(1) + j_r;
        end
        raddr = j_nxt[IW-1:0];
      end
      ST_DEL: begin
        // i = destination, j = source; rd_q = entry j read last cycle
        raddr = j_r[IW-1:0] + IW'(1);
        if (i_r < cnt_r) begin
          we = 1'b1; waddr = i_r[IW-1:0]; wdata = rd_q;
        end
        i_nxt = i_r + CW'(1);
        j_nxt = j_r + CW'(1);
        if (i_r + CW'(1) >= cnt_r) i_nxt = '0;
      end
      ST_STATS: begin
        raddr = i_r[IW-1:0];
        if (i_r >= cnt_r || !ready_r) ov_nxt = 1'b1;
      end
      ST_STATW: begin
        i_nxt = i_r + CW'(1);
        if (rd_free) begin
          tot_nxt = tot_r + rd_pay;
          if (rd_pay > lg_r) lg_nxt = rd_pay;
        end
      end
      ST_OUT: begin
        ov_nxt = 1'b1;
        if (ov_r && !out_stall) ov_nxt = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; cnt_r <= '0; ready_r <= 1'b0; ov_r <= 1'b0;
      start_r <= '0; len_r <= '0; i_r <= '0; j_r <= '0;
    end else begin
      st_r <= st_nxt; cnt_r <= cnt_nxt; ready_r <= ready_nxt; ov_r <= ov_nxt;
      start_r <= start_nxt; len_r <= len_nxt; i_r <= i_nxt; j_r <= j_nxt;
    end
  end
  always_ff @(posedge clk) begin
    pick_r <= pick_nxt; found_r <= found_nxt; size_r <= size_nxt;
    best_r <= best_nxt; poff_r <= poff_nxt; ppay_r <= ppay_nxt;
    mpay_r <= mpay_nxt; rel_r <= rel_nxt; act_r <= act_nxt;
    ok_r <= ok_nxt; err_r <= err_nxt; addr_r <= addr_nxt; gr_r <= gr_nxt;
    tot_r <= tot_nxt; lg_r <= lg_nxt;
  end

  // Result channel
  assign out_valid = ov_r;
  assign out_ok = ok_r;
  assign out_error_code = err_r;
  assign out_payload_addr = ok_r ? addr_r : '0;
  assign out_granted_bytes = ok_r ? gr_r : '0;
  assign out_free_total = tot_r;
  assign out_max_free = lg_r;

  // Checks
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= MAXC)
    else $error("block count above table depth");
  a_idle_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_IDLE) |-> !ov_r) else $error("result pending while idle");
  a_ok_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ok |-> out_error_code == ERR_NONE)
    else $error("success with error code");
  a_ready_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    ready_r |-> cnt_r != '0) else $error("ready heap with empty table");
endmodule
